### hw/rtl/orml_pkg.sv
// shared types and constants for the offset range map lookup block
// no dependencies; used by orml_table and offset_range_map_lookup_core
`default_nettype none

package orml_pkg;

    // field widths
    localparam int ENTRY_COUNT_W = 11;
    localparam int SLOT_W        = 10;
    localparam int KEY_W         = 64;
    localparam int VALUE_W       = 32;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 1024;

    // item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // input item
    typedef struct packed {
        logic               mode;
        logic [SLOT_W-1:0]  slot;
        logic [KEY_W-1:0]   offset;
        logic [VALUE_W-1:0] mapped_index;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [VALUE_W-1:0] found_index;
        logic               hit;
    } out_item_t;

    // one table entry as stored
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // lookup sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_FIRST,
        ST_KEY_LAST,
        ST_SEARCH,
        ST_VALUE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/orml_table.sv
// entry table: synchronous single-write, single-read memory with a registered read port
// depends on orml_pkg for the entry type
`default_nettype none

module orml_table #(
    parameter int TABLE_DEPTH = orml_pkg::TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire orml_pkg::entry_t     wr_data,
    input  wire logic [AW-1:0]        rd_addr,
    output orml_pkg::entry_t          rd_data
);

    orml_pkg::entry_t mem [TABLE_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/offset_range_map_lookup_core.sv
// offset range map lookup: binary search interval lookup over a sorted-key table
// depends on orml_pkg and orml_table
// write item: written from idle, the next item may follow in the next cycle
// query: first key, last key, then one search probe per cycle on the read port, then the value;
//   ends early on an empty table, below the first key, or at or past the last key
// one item in flight, next accepted in the cycle after its result is registered; reset clears control
`default_nettype none

module offset_range_map_lookup_core #(
    parameter int TABLE_DEPTH = orml_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire orml_pkg::in_item_t                  in_item,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output orml_pkg::out_item_t                      out_item,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [orml_pkg::ENTRY_COUNT_W-1:0]  cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);

    orml_pkg::state_t                      state_reg, state_next;
    logic [orml_pkg::ENTRY_COUNT_W-1:0]    count_reg;
    logic [orml_pkg::KEY_W-1:0]            off_reg;
    logic [LW-1:0]                         n_reg;
    logic [LW-1:0]                         first_reg;
    logic [LW-1:0]                         opl_reg;
    logic [AW-1:0]                         mid_reg;
    orml_pkg::out_item_t                   res_reg;
    logic                                  out_valid_reg;
    orml_pkg::out_item_t                   out_item_reg;

    logic [LW-1:0]                         live_count;
    logic                                  in_fire;
    logic                                  is_query;
    logic                                  slot_ok;
    logic                                  out_free;
    logic [LW-1:0]                         first_n;
    logic [LW-1:0]                         opl_n;
    logic [LW-1:0]                         span_n;
    logic [LW:0]                           sum_n;
    logic [AW-1:0]                         mid_n;
    logic                                  more_n;
    logic                                  key_lt;
    logic                                  key_gt;

    logic                                  wr_en;
    logic [AW-1:0]                         rd_addr;
    orml_pkg::entry_t                      wr_data;
    orml_pkg::entry_t                      rd_data;

    // entry table
    orml_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_item.slot)),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // input decode
    assign in_fire    = in_valid && in_ready;
    assign is_query   = (in_item.mode == orml_pkg::MODE_QUERY);
    assign slot_ok    = (32'(in_item.slot) < 32'(TABLE_DEPTH));
    assign live_count = (32'(count_reg) > 32'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                            : LW'(count_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign wr_data.key   = in_item.offset;
    assign wr_data.value = in_item.mapped_index;

    // probe key compare
    assign key_lt = (rd_data.key < off_reg);
    assign key_gt = (rd_data.key > off_reg);

    // next search bounds
    always_comb
    begin
        first_n = first_reg;
        opl_n   = opl_reg;
        case (state_reg)
            orml_pkg::ST_KEY_LAST:
            begin
                first_n = '0;
                opl_n   = n_reg;
            end
            orml_pkg::ST_SEARCH:
            begin
                if (key_lt)
                begin
                    first_n = LW'(mid_reg);
                end
                else if (key_gt)
                begin
                    opl_n = LW'(mid_reg);
                end
                else
                begin
                    // exact match: collapse the window onto the probed slot
                    first_n = LW'(mid_reg);
                    opl_n   = LW'(mid_reg) + LW'(1);
                end
            end
            default:
            begin
                first_n = first_reg;
                opl_n   = opl_reg;
            end
        endcase
    end

    // midpoint of the next window
    assign span_n = opl_n - first_n;
    assign more_n = (span_n > LW'(1));
    assign sum_n  = {1'b0, first_n} + {1'b0, opl_n};
    assign mid_n  = AW'(sum_n >> 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            orml_pkg::ST_IDLE:
            begin
                if (in_valid && is_query)
                begin
                    state_next = (live_count == '0) ? orml_pkg::ST_DONE
                                                    : orml_pkg::ST_KEY_FIRST;
                end
            end
            orml_pkg::ST_KEY_FIRST:
            begin
                state_next = key_gt ? orml_pkg::ST_DONE : orml_pkg::ST_KEY_LAST;
            end
            orml_pkg::ST_KEY_LAST:
            begin
                if (!key_gt)
                begin
                    state_next = orml_pkg::ST_DONE;
                end
                else
                begin
                    state_next = more_n ? orml_pkg::ST_SEARCH : orml_pkg::ST_VALUE;
                end
            end
            orml_pkg::ST_SEARCH:
            begin
                state_next = more_n ? orml_pkg::ST_SEARCH : orml_pkg::ST_VALUE;
            end
            orml_pkg::ST_VALUE:
            begin
                state_next = orml_pkg::ST_DONE;
            end
            orml_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = orml_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = orml_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake and table access
    always_comb
    begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            orml_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                wr_en    = in_valid && !is_query && slot_ok;
                rd_addr  = '0;
            end
            orml_pkg::ST_KEY_FIRST:
            begin
                rd_addr = AW'(n_reg - LW'(1));
            end
            orml_pkg::ST_KEY_LAST,
            orml_pkg::ST_SEARCH:
            begin
                rd_addr = more_n ? mid_n : AW'(first_n);
            end
            orml_pkg::ST_VALUE,
            orml_pkg::ST_DONE:
            begin
                rd_addr = '0;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= orml_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
            if (state_reg == orml_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == orml_pkg::ST_IDLE && in_fire && is_query)
        begin
            off_reg             <= in_item.offset;
            n_reg               <= live_count;
            res_reg.found_index <= '0;
            res_reg.hit         <= 1'b0;
        end
        if (state_reg == orml_pkg::ST_KEY_LAST || state_reg == orml_pkg::ST_SEARCH)
        begin
            first_reg <= first_n;
            opl_reg   <= opl_n;
            mid_reg   <= mid_n;
        end
        if (state_reg == orml_pkg::ST_VALUE)
        begin
            res_reg.found_index <= rd_data.value;
            res_reg.hit         <= 1'b1;
        end
        if (state_reg == orml_pkg::ST_DONE && out_free)
        begin
            out_item_reg <= res_reg;
        end
    end

    // outputs
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// testbench for offset_range_map_lookup_core: table writes, entry-count settings and
// interval queries, checked item by item against a built-in search predictor
// depends on orml_pkg and the offset_range_map_lookup_core rtl

module tb;

    localparam int DEPTH       = orml_pkg::TABLE_DEPTH_DEF;
    localparam int SETTLE      = 40;
    localparam int STALL_LIMIT = 2000;

    logic                               clk;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    orml_pkg::in_item_t                 in_item   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    orml_pkg::out_item_t                out_item;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [orml_pkg::ENTRY_COUNT_W-1:0] cfg_data  = '0;

    // stimulus side: items waiting to go out and the keys the generator has written
    orml_pkg::in_item_t         items_to_send[$];
    logic [orml_pkg::KEY_W-1:0] gen_keys[DEPTH];
    int                         gen_live;
    int                         stall_pct = 37;

    // predictor side: shadow table, entry count and lookups still owed by the block
    logic [orml_pkg::KEY_W-1:0]   tbl_keys[DEPTH];
    logic [orml_pkg::VALUE_W-1:0] tbl_vals[DEPTH];
    int                           tbl_count;
    orml_pkg::out_item_t          lookups_due[$];

    int mismatches;
    int n_writes;
    int n_queries;
    int n_hits;
    int n_cfg;
    int quiet_cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    offset_range_map_lookup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // entry found by binary search whose key does not exceed the offset, only inside [key0, key_last)
    function automatic orml_pkg::out_item_t cover_lookup(logic [orml_pkg::KEY_W-1:0] off);
        int                  n;
        int                  lo;
        int                  hi;
        int                  mid;
        orml_pkg::out_item_t r;
        r = '0;
        n = (tbl_count > DEPTH) ? DEPTH : tbl_count;
        if (n > 0 && tbl_keys[0] <= off && off < tbl_keys[n-1])
        begin
            lo = 0;
            hi = n;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) / 2;
                if (tbl_keys[mid] < off)
                    lo = mid;
                else if (tbl_keys[mid] > off)
                    hi = mid;
                else
                begin
                    lo = mid;
                    break;
                end
            end
            r.found_index = tbl_vals[lo];
            r.hit         = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [orml_pkg::KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_write(int slot, logic [orml_pkg::KEY_W-1:0] key,
                              logic [orml_pkg::VALUE_W-1:0] val);
        orml_pkg::in_item_t it;
        it.mode         = orml_pkg::MODE_WRITE;
        it.slot         = orml_pkg::SLOT_W'(slot);
        it.offset       = key;
        it.mapped_index = val;
        items_to_send.push_back(it);
        gen_keys[slot] = key;
    endtask

    task automatic push_query(logic [orml_pkg::KEY_W-1:0] off);
        orml_pkg::in_item_t it;
        it.mode         = orml_pkg::MODE_QUERY;
        it.slot         = orml_pkg::SLOT_W'($urandom_range(0, DEPTH - 1));
        it.offset       = off;
        it.mapped_index = $urandom;
        items_to_send.push_back(it);
    endtask

    // everything sent and answered, then let a trailing write settle
    task automatic wait_idle();
        while (items_to_send.size() != 0 || in_valid || lookups_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_count(int count);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= count[orml_pkg::ENTRY_COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_count = count;
        gen_live  = (count > DEPTH) ? DEPTH : count;
        n_cfg++;
    endtask

    // ascending keys in slots 0..n-1, random gaps with some repeated keys
    task automatic fill_sorted(int n);
        logic [orml_pkg::KEY_W-1:0] key;
        logic [orml_pkg::KEY_W-1:0] budget;
        logic [orml_pkg::KEY_W-1:0] cap;
        if (n == 0)
            return;
        key    = rand64() >> $urandom_range(1, 63);
        budget = ~key / 64'(n);
        for (int i = 0; i < n; i++)
        begin
            push_write(i, key, $urandom);
            cap = budget >> $urandom_range(0, 40);
            if (cap != 0 && $urandom_range(0, 19) != 0)
                key += rand64() % cap;
        end
    endtask

    // mostly in-span queries, some outside the span, a little write noise
    task automatic random_queries(int num);
        logic [orml_pkg::KEY_W-1:0] lo_key;
        logic [orml_pkg::KEY_W-1:0] hi_key;
        logic [orml_pkg::KEY_W-1:0] q;
        int                         i;
        int                         pick;
        int                         slot;
        for (int k = 0; k < num; k++)
        begin
            pick = $urandom_range(0, 99);
            q    = rand64();
            if (gen_live > 0)
            begin
                lo_key = gen_keys[0];
                hi_key = gen_keys[gen_live-1];
                i      = $urandom_range(0, gen_live - 1);
                // inside one interval
                if (pick < 60 && i + 1 < gen_live)
                begin
                    q = gen_keys[i];
                    if (gen_keys[i+1] > gen_keys[i])
                        q += rand64() % (gen_keys[i+1] - gen_keys[i]);
                end
                // exact key
                else if (pick < 70)
                    q = gen_keys[i];
                // below the first key
                else if (pick < 80)
                    q = (lo_key != 0) ? rand64() % lo_key : lo_key;
                // at or past the last key
                else if (pick < 90)
                    q = hi_key | (rand64() >> $urandom_range(0, 63));
            end
            if (pick >= 95)
            begin
                // writes that leave the searched part of the table sorted
                if (gen_live < DEPTH)
                    push_write($urandom_range(gen_live, DEPTH - 1), rand64(), $urandom);
                else
                begin
                    slot = $urandom_range(0, DEPTH - 1);
                    push_write(slot, gen_keys[slot], $urandom);
                end
            end
            else
                push_query(q);
        end
    endtask

    // input driver: updates the predictor on each accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_item.mode == orml_pkg::MODE_WRITE)
                begin
                    tbl_keys[in_item.slot] = in_item.offset;
                    tbl_vals[in_item.slot] = in_item.mapped_index;
                    n_writes++;
                end
                else
                begin
                    lookups_due.push_back(cover_lookup(in_item.offset));
                    n_queries++;
                end
            end
            // next item once the current one is gone, with random gaps
            if (!in_valid || in_ready)
            begin
                if (items_to_send.size() > 0 && $urandom_range(0, 99) >= stall_pct)
                begin
                    in_valid <= 1'b1;
                    in_item  <= items_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin : check_result
                orml_pkg::out_item_t want;
                if (lookups_due.size() == 0)
                begin
                    $error("unexpected result: found_index %h hit %b",
                           out_item.found_index, out_item.hit);
                    mismatches++;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (want.hit)
                        n_hits++;
                    if (out_item.found_index !== want.found_index)
                    begin
                        $error("found_index: expected %h, got %h",
                               want.found_index, out_item.found_index);
                        mismatches++;
                    end
                    if (out_item.hit !== want.hit)
                    begin
                        $error("hit: expected %b, got %b", want.hit, out_item.hit);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("** offset_range_map_lookup_core: FAILED **");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int sizes[7] = '{2, 3, 0, 5, 17, 1, 64};
        int n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table always misses
        set_count(0);
        push_query('0);
        push_query('1);
        // four entries covering both key extremes, plus the top slot
        push_write(0, '0, '1);
        push_write(1, 64'h100, '0);
        push_write(2, 64'h200, 32'h2);
        push_write(3, '1, 32'h3);
        push_write(DEPTH - 1, rand64(), $urandom);
        // single entry: span is empty
        set_count(1);
        push_query('0);
        // interval edges, exact matches, last key excluded from the span
        set_count(4);
        push_query('0);
        push_query(64'h80);
        push_query(64'h100);
        push_query(64'h1ff);
        push_query(64'h200);
        push_query(64'hffff_ffff_ffff_fffe);
        push_query('1);
        // out-of-order key in the middle, search runs the same steps
        push_write(1, 64'h300, 32'hdead_beef);
        push_query(64'h250);
        push_query(64'h300);

        // full table with no idling on either side
        set_count(DEPTH);
        stall_pct = 0;
        fill_sorted(DEPTH);
        random_queries(150);
        // count above depth saturates
        set_count(2047);
        stall_pct = 37;
        random_queries(60);

        // short tables with fresh sorted keys
        foreach (sizes[j])
        begin
            set_count(sizes[j]);
            fill_sorted(sizes[j]);
            random_queries(40);
        end
        repeat (3)
        begin
            n = $urandom_range(2, 48);
            set_count(n);
            fill_sorted(n);
            random_queries(40);
        end

        // unsorted keys
        n = $urandom_range(20, 40);
        set_count(n);
        for (int i = 0; i < n; i++)
            push_write(i, rand64(), $urandom);
        random_queries(40);

        wait_idle();
        $display("run covered %0d table writes and %0d queries (%0d hits) across %0d count settings",
                 n_writes, n_queries, n_hits, n_cfg);
        $display("counts ranged from empty and single-entry tables to full and saturated depth");
        if (mismatches == 0)
            $display("** offset_range_map_lookup_core: PASSED **");
        else
            $display("** offset_range_map_lookup_core: FAILED **");
        $finish;
    end

endmodule

### offset_range_map_lookup_core.f
hw/rtl/orml_pkg.sv
hw/rtl/orml_table.sv
hw/rtl/offset_range_map_lookup_core.sv
sim/tb.sv
